### hw/rtl/stk_pkg.sv
// Shared types and constants of the s-expression tokenizer.
// Used by stk_lex, stk_outq and s_expression_tokenizer; no dependencies.
`timescale 1ns / 1ps

package stk_pkg;

  localparam int LENGTH_WIDTH = 16;
  localparam int LINE_WIDTH   = 16;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);

  // source bytes with a meaning of their own
  localparam logic [7:0] CH_EOI    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;

  typedef enum logic [1:0] {
    EV_TEXT     = 2'd0,
    EV_DONE     = 2'd1,
    EV_UNTERM   = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    TK_NONE   = 3'd0,
    TK_ATOM   = 3'd1,
    TK_STRING = 3'd2,
    TK_PUNCT  = 3'd3,
    TK_EOI    = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    M_IDLE    = 5'b00001,
    M_COMMENT = 5'b00010,
    M_ATOM    = 5'b00100,
    M_STRING  = 5'b01000,
    M_ESCAPE  = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [15:0] text_length;
    logic [15:0] line_number;
    logic [7:0]  value_byte;
    kind_t       token_kind;
    event_t      event_res;
    logic        last_result;
  } res_t;

  // what the lexer hands to the output queue for one byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

### hw/rtl/stk_lex.sv
// Lexer state and next-state logic: one source byte per accepted word,
// zero to two results out. Depends on stk_pkg.
`timescale 1ns / 1ps

module stk_lex (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [7:0]    ch,
  output stk_pkg::push_t push
);

  localparam logic [stk_pkg::LENGTH_WIDTH-1:0] LEN_MAX = '1;
  localparam logic [stk_pkg::LINE_WIDTH-1:0]   LINE_MAX = '1;

  stk_pkg::mode_t mode_r, mode_nxt;
  logic [stk_pkg::LINE_WIDTH-1:0]   line_r, line_nxt;
  logic [stk_pkg::LENGTH_WIDTH-1:0] len_r, len_nxt, len_inc, len_sel;

  logic is_punct, is_ws_idle, ends_atom, bump;
  stk_pkg::res_t  b_res, r0, r1;
  logic           b_has, b_bump;
  stk_pkg::mode_t b_mode;
  logic [stk_pkg::LENGTH_WIDTH-1:0] b_len;
  logic [1:0] cnt;
  logic [7:0] esc_byte;

  function automatic stk_pkg::res_t mk(stk_pkg::event_t ev, stk_pkg::kind_t k,
                                       logic [7:0] v, logic [15:0] ln,
                                       logic [15:0] tl);
    stk_pkg::res_t r;
    r.event_res   = ev;
    r.token_kind  = k;
    r.value_byte  = v;
    r.line_number = ln;
    r.text_length = tl;
    r.last_result = 1'b0;
    return r;
  endfunction

  logic [15:0] line16;
  assign line16  = 16'(line_r);
  assign len_inc = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;

  always_comb begin
    is_punct = (ch == stk_pkg::CH_LPAR) || (ch == stk_pkg::CH_RPAR) ||
               (ch == stk_pkg::CH_LBRK) || (ch == stk_pkg::CH_RBRK) ||
               (ch == stk_pkg::CH_DOT) || (ch == stk_pkg::CH_QUOTE) ||
               (ch == stk_pkg::CH_BTICK) || (ch == stk_pkg::CH_COMMA);
    is_ws_idle = (ch == stk_pkg::CH_SPACE) || (ch == stk_pkg::CH_TAB) ||
                 (ch == stk_pkg::CH_VT) || (ch == stk_pkg::CH_FF) ||
                 (ch == stk_pkg::CH_CR);
    ends_atom = (ch == stk_pkg::CH_EOI) || is_punct || (ch == stk_pkg::CH_SEMI) ||
                (ch == stk_pkg::CH_SPACE) || (ch == stk_pkg::CH_TAB) ||
                (ch == stk_pkg::CH_NL);
    esc_byte = (ch == stk_pkg::CH_LC_N) ? stk_pkg::CH_NL :
               (ch == stk_pkg::CH_LC_T) ? stk_pkg::CH_TAB : ch;
  end

  // handling of a byte between tokens (also the byte that ends an atom)
  always_comb begin
    b_mode = stk_pkg::M_IDLE;
    b_has  = 1'b0;
    b_bump = 1'b0;
    b_len  = len_r;
    b_res  = mk(stk_pkg::EV_DONE, stk_pkg::TK_EOI, 8'h00, line16, 16'h0000);
    if (ch == stk_pkg::CH_EOI) begin
      b_has = 1'b1;
    end else if (ch == stk_pkg::CH_NL) begin
      b_bump = 1'b1;
    end else if (is_ws_idle) begin
      b_has = 1'b0;
    end else if (ch == stk_pkg::CH_SEMI) begin
      b_mode = stk_pkg::M_COMMENT;
    end else if (ch == stk_pkg::CH_DQUOTE) begin
      b_len  = '0;
      b_mode = stk_pkg::M_STRING;
    end else if (is_punct) begin
      b_has = 1'b1;
      b_res = mk(stk_pkg::EV_DONE, stk_pkg::TK_PUNCT, ch, line16, 16'h0000);
    end else begin
      // first byte of an atom: length restarts at one
      b_has  = 1'b1;
      b_len  = stk_pkg::LENGTH_WIDTH'(1);
      b_mode = stk_pkg::M_ATOM;
      b_res  = mk(stk_pkg::EV_TEXT, stk_pkg::TK_ATOM, ch, line16, 16'h0001);
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    len_sel  = len_r;
    bump     = 1'b0;
    cnt      = 2'd0;
    r0       = b_res;
    r1       = b_res;
    case (mode_r)
      stk_pkg::M_COMMENT: begin
        if (ch == stk_pkg::CH_EOI) begin
          cnt      = 2'd1;
          r0       = mk(stk_pkg::EV_DONE, stk_pkg::TK_EOI, 8'h00, line16, 16'h0000);
          mode_nxt = stk_pkg::M_IDLE;
        end else if (ch == stk_pkg::CH_NL) begin
          bump     = 1'b1;
          mode_nxt = stk_pkg::M_IDLE;
        end
      end
      stk_pkg::M_ATOM: begin
        if (ends_atom) begin
          r0       = mk(stk_pkg::EV_DONE, stk_pkg::TK_ATOM, 8'h00, line16,
                        16'(len_r));
          r1       = b_res;
          cnt      = b_has ? 2'd2 : 2'd1;
          mode_nxt = b_mode;
          len_sel  = b_len;
          bump     = b_bump;
        end else begin
          cnt     = 2'd1;
          len_sel = len_inc;
          r0      = mk(stk_pkg::EV_TEXT, stk_pkg::TK_ATOM, ch, line16, 16'(len_inc));
        end
      end
      stk_pkg::M_STRING, stk_pkg::M_ESCAPE: begin
        if (ch == stk_pkg::CH_EOI) begin
          cnt      = 2'd2;
          r0       = mk(stk_pkg::EV_UNTERM, stk_pkg::TK_STRING, 8'h00, line16,
                        16'(len_r));
          r1       = mk(stk_pkg::EV_DONE, stk_pkg::TK_EOI, 8'h00, line16, 16'h0000);
          mode_nxt = stk_pkg::M_IDLE;
        end else if (mode_r == stk_pkg::M_ESCAPE) begin
          cnt      = 2'd1;
          len_sel  = len_inc;
          bump     = (ch == stk_pkg::CH_NL);
          r0       = mk(stk_pkg::EV_TEXT, stk_pkg::TK_STRING, esc_byte, line16,
                        16'(len_inc));
          mode_nxt = stk_pkg::M_STRING;
        end else if (ch == stk_pkg::CH_DQUOTE) begin
          cnt      = 2'd1;
          r0       = mk(stk_pkg::EV_DONE, stk_pkg::TK_STRING, 8'h00, line16,
                        16'(len_r));
          mode_nxt = stk_pkg::M_IDLE;
        end else if (ch == stk_pkg::CH_BSLASH) begin
          mode_nxt = stk_pkg::M_ESCAPE;
        end else begin
          cnt     = 2'd1;
          len_sel = len_inc;
          bump    = (ch == stk_pkg::CH_NL);
          r0      = mk(stk_pkg::EV_TEXT, stk_pkg::TK_STRING, ch, line16,
                       16'(len_inc));
        end
      end
      default: begin
        // idle, and any mode code without a meaning
        r0       = b_res;
        cnt      = b_has ? 2'd1 : 2'd0;
        mode_nxt = b_mode;
        len_sel  = b_len;
        bump     = b_bump;
      end
    endcase
    len_nxt  = len_sel;
    line_nxt = (bump && (line_r != LINE_MAX)) ? line_r + 1'b1 : line_r;

    // mark the final result of this byte
    if (cnt == 2'd2) begin
      r1.last_result = 1'b1;
    end else begin
      r0.last_result = 1'b1;
    end
    push.cnt = en ? cnt : 2'd0;
    push.r0  = r0;
    push.r1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stk_pkg::M_IDLE;
      line_r <= stk_pkg::LINE_WIDTH'(1);
      len_r  <= '0;
    end else if (en) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

### hw/rtl/stk_outq.sv
// Result queue: takes up to two results a cycle, gives one a cycle while
// out_ready is high. Depends on stk_pkg.
`timescale 1ns / 1ps

module stk_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  stk_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output stk_pkg::res_t  out_res
);

  stk_pkg::res_t mem [stk_pkg::QDEPTH];
  logic [stk_pkg::QAW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [stk_pkg::QAW:0]   count_r, count_nxt;
  logic pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem[rd_r];
  assign pop       = out_valid && out_ready;
  // two free slots needed, since one word can cause two results
  assign room      = (count_r <= (stk_pkg::QAW+1)'(stk_pkg::QDEPTH - 2));

  always_comb begin
    wr_nxt    = wr_r + stk_pkg::QAW'(push.cnt);
    rd_nxt    = pop ? rd_r + 1'b1 : rd_r;
    count_nxt = count_r + (stk_pkg::QAW+1)'(push.cnt) - (stk_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_r + 1'b1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### hw/rtl/s_expression_tokenizer.sv
// S-expression tokenizer, top level: stream ports around the lexer and
// the result queue. Depends on stk_pkg, stk_lex, stk_outq.
`timescale 1ns / 1ps

// One source byte enters per cycle; byte 0 ends the input. Each byte is
// lexed in the cycle it is accepted and its zero to two results go into
// a four-word queue, which drains one word per cycle while out_tready is
// high. in_tready drops only while fewer than two queue slots are free, so
// a stream whose bytes average at most one result runs at one byte per
// cycle; an atom ending at a punctuation byte or at end of input gives two
// results. Line count and token length saturate at all ones; tuser carries
// event and token kind, and tlast marks the last result caused by a byte.
module s_expression_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] value_byte, [23:8] line_number, [39:24] text_length
  output logic [39:0] out_tdata,
  output logic [4:0]  out_tuser,  // [1:0] event_res, [4:2] token_kind
  output logic        out_tlast
);

  stk_pkg::push_t push;
  stk_pkg::res_t  res;
  logic           room;

  assign in_tready = room;

  stk_lex u_lex (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_tvalid && room),
    .ch    (in_tdata),
    .push  (push)
  );

  stk_outq u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.text_length, res.line_number, res.value_byte};
  assign out_tuser = {res.token_kind, res.event_res};
  assign out_tlast = res.last_result;

endmodule
